/* rtl/core/kpd_pkg.sv */
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and constants of the key press duration classifier
// Holds field widths, register indexes, reset values and event codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

    // Field widths.
    localparam int unsigned SPEED_W   = 8;
    localparam int unsigned PRESS_W   = 14;
    localparam int unsigned RELEASE_W = 7;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 14;

    typedef logic [1:0] t_gear;
    typedef logic [1:0] t_mode;

    // Register indexes on the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_WINDOW = 3'd0,
        CFG_MIN_PRESS    = 3'd1,
        CFG_MIN_RELEASE  = 3'd2,
        CFG_LONG_PRESS   = 3'd3,
        CFG_HOLD_CAP     = 3'd4
    } t_cfg_idx;

    // Key event codes.
    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    // Highest mode that still follows the speed signal; above it the gear is forced.
    localparam t_mode MODE_ALTERNATING = 2'd1;

    localparam t_gear GEAR_LOW  = 2'd0;
    localparam t_gear GEAR_HIGH = 2'd1;

    // Press ticks beyond which a press is considered real and the release count restarts.
    localparam logic [PRESS_W-1:0]   PRESS_DEBOUNCE = 14'd10;
    // Saturation value of the release counter.
    localparam logic [RELEASE_W-1:0] RELEASE_SAT    = 7'd100;

    // Register reset values.
    localparam logic [SPEED_W-1:0]   RST_SPEED_WINDOW = 8'd15;
    localparam logic [7:0]           RST_MIN_PRESS    = 8'd50;
    localparam logic [RELEASE_W-1:0] RST_MIN_RELEASE  = 7'd50;
    localparam logic [PRESS_W-1:0]   RST_LONG_PRESS   = 14'd2000;
    localparam logic [PRESS_W-1:0]   RST_HOLD_CAP     = 14'd10000;

endpackage

`default_nettype wire

/* rtl/core/key_press_duration_classifier.sv */
// ----------------------------------------------------------------------------
// key_press_duration_classifier: speed gear selection and key press timing
// One beat per 1 ms tick; returns the held gear and a short or long key event.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the s_axis channel is one tick carrying the raw speed level,
// the raw (active low) temperature key level and the operating mode. For every
// input beat exactly one beat leaves on m_axis with the gear held after that
// tick and a key event (none, short or long press).
// The configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data)
// writes the five timing registers; o_cfg_ready is always high, and indexes
// beyond the register list are dropped. Write only while the block is idle.
// A beat lands in the input register, and from there the tick update runs
// through short compare and increment logic into the result register,
// which drives m_axis. One beat is taken every cycle as long as the result
// register drains; when the receiver stalls, the result holds, the input
// register fills, and then s_axis_tready drops until the receiver takes the
// waiting beat.
// Reset (synchronous, active low) clears both pipeline valids and all
// counters and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_duration_classifier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input ticks.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] speed_level, [1] temp_level, [3:2] mode
    // Results.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [1:0] target_gear, [3:2] key_event
    // Configuration writes.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [kpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [kpd_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    // Timing registers.
    logic [kpd_pkg::SPEED_W-1:0]   r_speed_window;
    logic [7:0]                    r_min_press;
    logic [kpd_pkg::RELEASE_W-1:0] r_min_release;
    logic [kpd_pkg::PRESS_W-1:0]   r_long_press;
    logic [kpd_pkg::PRESS_W-1:0]   r_hold_cap;

    // Input register.
    logic                r_in_valid;
    logic                r_in_speed;
    logic                r_in_temp;
    kpd_pkg::t_mode      r_in_mode;

    // Tick state.
    logic [kpd_pkg::SPEED_W-1:0]   r_speed_count, n_speed_count;
    logic                          r_last_speed,  n_last_speed;
    kpd_pkg::t_gear                r_gear,        n_gear;
    logic [kpd_pkg::PRESS_W-1:0]   r_press_count, n_press_count;
    logic [kpd_pkg::RELEASE_W-1:0] r_release_count, n_release_count;
    kpd_pkg::t_event               n_event;

    // Result register.
    logic                r_out_valid;
    kpd_pkg::t_gear      r_out_gear;
    kpd_pkg::t_event     r_out_event;

    logic w_advance;
    logic w_in_take;
    logic [kpd_pkg::PRESS_W-1:0] w_min_press_ext;

    assign o_cfg_ready = 1'b1;

    // The input register moves into the result register whenever that one is
    // empty or being drained this cycle.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_event, r_out_gear};

    assign w_min_press_ext = {{(kpd_pkg::PRESS_W - 8){1'b0}}, r_min_press};

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_window <= kpd_pkg::RST_SPEED_WINDOW;
            r_min_press    <= kpd_pkg::RST_MIN_PRESS;
            r_min_release  <= kpd_pkg::RST_MIN_RELEASE;
            r_long_press   <= kpd_pkg::RST_LONG_PRESS;
            r_hold_cap     <= kpd_pkg::RST_HOLD_CAP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                kpd_pkg::CFG_SPEED_WINDOW: r_speed_window <= i_cfg_data[kpd_pkg::SPEED_W-1:0];
                kpd_pkg::CFG_MIN_PRESS:    r_min_press    <= i_cfg_data[7:0];
                kpd_pkg::CFG_MIN_RELEASE:  r_min_release  <= i_cfg_data[kpd_pkg::RELEASE_W-1:0];
                kpd_pkg::CFG_LONG_PRESS:   r_long_press   <= i_cfg_data;
                kpd_pkg::CFG_HOLD_CAP:     r_hold_cap     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One tick of the speed and key logic.
    always_comb begin
        n_speed_count   = r_speed_count;
        n_last_speed    = r_last_speed;
        n_gear          = r_gear;
        n_press_count   = r_press_count;
        n_release_count = r_release_count;
        n_event         = kpd_pkg::EV_NONE;

        // Speed gear: the window counter saturates at the window and drops
        // the gear to low; a rising edge inside the window picks high gear.
        if (r_in_mode <= kpd_pkg::MODE_ALTERNATING) begin
            if (r_speed_count < r_speed_window) begin
                n_speed_count = r_speed_count + 1'b1;
            end else begin
                n_speed_count = r_speed_window;
                n_gear        = kpd_pkg::GEAR_LOW;
            end
            if (r_in_speed && !r_last_speed) begin
                if (n_speed_count < r_speed_window) begin
                    n_gear = kpd_pkg::GEAR_HIGH;
                end
                n_speed_count = '0;
            end
            n_last_speed = r_in_speed;
        end else begin
            n_gear = r_in_mode;
        end

        // Temperature key, pressed when low.
        if (!r_in_temp) begin
            if (r_press_count < r_hold_cap) begin
                n_press_count = r_press_count + 1'b1;
            end else begin
                n_press_count = r_hold_cap;
            end
            if (n_press_count > kpd_pkg::PRESS_DEBOUNCE) begin
                n_release_count = '0;
            end
        end else begin
            if (r_release_count < kpd_pkg::RELEASE_SAT) begin
                n_release_count = r_release_count + 1'b1;
            end
            if (n_release_count > r_min_release) begin
                if (r_press_count > w_min_press_ext && r_press_count < r_long_press) begin
                    n_event       = kpd_pkg::EV_SHORT;
                    n_press_count = '0;
                end else if (r_press_count >= r_long_press && r_press_count <= r_hold_cap) begin
                    n_event       = kpd_pkg::EV_LONG;
                    n_press_count = '0;
                end else if (r_press_count < w_min_press_ext) begin
                    n_press_count = '0;
                end
            end
        end
    end

    // Pipeline valids and tick state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_speed_count   <= '0;
            r_last_speed    <= 1'b0;
            r_gear          <= kpd_pkg::GEAR_LOW;
            r_press_count   <= '0;
            r_release_count <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid     <= 1'b1;
                r_speed_count   <= n_speed_count;
                r_last_speed    <= n_last_speed;
                r_gear          <= n_gear;
                r_press_count   <= n_press_count;
                r_release_count <= n_release_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_speed <= s_axis_tdata[0];
            r_in_temp  <= s_axis_tdata[1];
            r_in_mode  <= s_axis_tdata[3:2];
        end
        if (w_advance) begin
            r_out_gear  <= n_gear;
            r_out_event <= n_event;
        end
    end

`ifndef SYNTHESIS
    // The release counter never runs past its saturation value.
    a_release_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_release_count <= kpd_pkg::RELEASE_SAT)
        else $error("release counter above saturation");

    // A forced mode shows up as the gear of the very result it produced.
    a_forced_gear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_mode > kpd_pkg::MODE_ALTERNATING))
        |=> (r_out_gear == $past(r_in_mode)))
        else $error("forced mode not reflected in gear");

    // Any classified press clears the press counter.
    a_event_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (n_event != kpd_pkg::EV_NONE)) |=> (r_press_count == '0))
        else $error("press counter not cleared after event");

    // The result register is only refilled from a valid input register.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !r_in_valid) |=> !r_out_valid)
        else $error("result appeared without an input beat");
`endif

endmodule

`default_nettype wire

/* sim/tb_key_press_duration_classifier.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_press_duration_classifier: self-checking bench for the gear and key timer
// Streams tick beats through the block under random back pressure and idle gaps.
// A predictor built into the bench computes the expected gear and key event for
// each accepted tick, and every result beat is checked against it in order.
// ----------------------------------------------------------------------------

module tb_key_press_duration_classifier;

    // Mode codes. Only the alternating mode is named in the package.
    localparam kpd_pkg::t_mode MODE_NORMAL   = 2'd0;
    localparam kpd_pkg::t_mode MODE_CHILD    = 2'd2;
    localparam kpd_pkg::t_mode MODE_FAST_DRY = 2'd3;

    // The temperature key is active low.
    localparam logic KEY_DOWN = 1'b0;
    localparam logic KEY_UP   = 1'b1;

    // Register indexes past the end of the list; writes there must be dropped.
    localparam logic [kpd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [kpd_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    // Cycles allowed for the pipeline to empty before config writes.
    localparam int DRAIN_CYCLES   = 4;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        kpd_pkg::t_gear  gear;
        kpd_pkg::t_event key_ev;
    } t_tick_result;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata  = '0;   // [0] speed_level, [1] temp_level, [3:2] mode
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [7:0]                    m_axis_tdata;         // [1:0] target_gear, [3:2] key_event
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [kpd_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [kpd_pkg::CFG_DAT_W-1:0] i_cfg_data    = '0;

    always #5 i_clk = ~i_clk;

    key_press_duration_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state. The timing registers start at their reset values and
    // follow every write made on the configuration channel.
    // ------------------------------------------------------------------------
    logic [kpd_pkg::SPEED_W-1:0]   win_ticks       = kpd_pkg::RST_SPEED_WINDOW;
    logic [7:0]                    min_press_ticks = kpd_pkg::RST_MIN_PRESS;
    logic [kpd_pkg::RELEASE_W-1:0] min_rel_ticks   = kpd_pkg::RST_MIN_RELEASE;
    logic [kpd_pkg::PRESS_W-1:0]   long_ticks      = kpd_pkg::RST_LONG_PRESS;
    logic [kpd_pkg::PRESS_W-1:0]   cap_ticks       = kpd_pkg::RST_HOLD_CAP;

    logic [kpd_pkg::SPEED_W-1:0]   spd_count   = '0;
    logic                          spd_prev    = 1'b0;
    kpd_pkg::t_gear                gear_now    = kpd_pkg::GEAR_LOW;
    logic [kpd_pkg::PRESS_W-1:0]   press_ticks = '0;
    logic [kpd_pkg::RELEASE_W-1:0] rel_ticks   = '0;

    // Expected results, oldest first.
    t_tick_result gear_event_q[$];

    int  err_count   = 0;
    int  ticks_sent  = 0;
    int  idle_cycles = 0;
    // While set, neither side inserts gaps or stalls.
    bit  quiet       = 1'b0;

    // Speed pin generator: a square wave whose half period is picked per press.
    logic spd_drive = 1'b0;
    int   spd_half  = 1;
    int   spd_left  = 0;

    // Advances the predicted state by one tick and returns the result beat
    // that the block must produce for it.
    function automatic t_tick_result advance_tick(input logic spd, input logic key,
                                                  input kpd_pkg::t_mode md);
        t_tick_result r;
        r.key_ev = kpd_pkg::EV_NONE;

        // Gear: the two speed-following modes time rising edges against the
        // window; the other modes simply force the gear to the mode value.
        if (md <= kpd_pkg::MODE_ALTERNATING) begin
            if (spd_count < win_ticks) begin
                spd_count = spd_count + 1'b1;
            end else begin
                spd_count = win_ticks;
                gear_now  = kpd_pkg::GEAR_LOW;
            end
            if (spd && !spd_prev) begin
                if (spd_count < win_ticks) begin
                    gear_now = kpd_pkg::GEAR_HIGH;
                end
                spd_count = '0;
            end
            spd_prev = spd;
        end else begin
            gear_now = md;
        end

        // Key: a press saturates at the cap; only a press longer than the
        // debounce count restarts the release timer.
        if (key == KEY_DOWN) begin
            if (press_ticks < cap_ticks) begin
                press_ticks = press_ticks + 1'b1;
            end else begin
                press_ticks = cap_ticks;
            end
            if (press_ticks > kpd_pkg::PRESS_DEBOUNCE) begin
                rel_ticks = '0;
            end
        end else begin
            if (rel_ticks < kpd_pkg::RELEASE_SAT) begin
                rel_ticks = rel_ticks + 1'b1;
            end
            // Once released long enough the press is classified. A count equal to the minimum but
            // under the long threshold, or above a lowered cap and under neither threshold, stays.
            if (rel_ticks > min_rel_ticks) begin
                if (press_ticks > min_press_ticks && press_ticks < long_ticks) begin
                    r.key_ev    = kpd_pkg::EV_SHORT;
                    press_ticks = '0;
                end else if (press_ticks >= long_ticks && press_ticks <= cap_ticks) begin
                    r.key_ev    = kpd_pkg::EV_LONG;
                    press_ticks = '0;
                end else if (press_ticks < min_press_ticks) begin
                    press_ticks = '0;
                end
            end
        end

        r.gear = gear_now;
        return r;
    endfunction

    // Idle length: mostly short, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Next level of the speed pin.
    function automatic logic next_speed();
        if (spd_left == 0) begin
            spd_drive = ~spd_drive;
            spd_left  = spd_half;
        end
        spd_left = spd_left - 1;
        return spd_drive;
    endfunction

    // Register data with the bits above the field randomly filled half of the
    // time, since the block keeps only the field's own width.
    function automatic logic [kpd_pkg::CFG_DAT_W-1:0] cfg_value(input int v, input int width);
        logic [kpd_pkg::CFG_DAT_W-1:0] junk;
        junk = kpd_pkg::CFG_DAT_W'($urandom) << width;
        if ($urandom_range(0, 1) == 1) begin
            return kpd_pkg::CFG_DAT_W'(v) | junk;
        end
        return kpd_pkg::CFG_DAT_W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls on tready, and an in-order check of every
    // result beat. Values are sampled as they were just before the edge.
    // ------------------------------------------------------------------------
    int ready_left = 0;

    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
            ready_left    <= 0;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (m_axis_tready && $urandom_range(0, 2) == 0) begin
            m_axis_tready <= 1'b0;
            ready_left    <= idle_len() - 1;
        end else begin
            m_axis_tready <= 1'b1;
            ready_left    <= $urandom_range(0, 20);
        end
    end

    always @(posedge i_clk) begin
        t_tick_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (gear_event_q.size() == 0) begin
                $error("result beat with no tick waiting for it: tdata %h", m_axis_tdata);
                err_count++;
            end else begin
                want = gear_event_q.pop_front();
                if (m_axis_tdata[1:0] !== want.gear) begin
                    $error("target_gear mismatch: expected %0d, actual %0d",
                           want.gear, m_axis_tdata[1:0]);
                    err_count++;
                end
                if (m_axis_tdata[3:2] !== want.key_ev) begin
                    $error("key_event mismatch: expected %0d, actual %0d",
                           want.key_ev, m_axis_tdata[3:2]);
                    err_count++;
                end
            end
        end
    end

    // Any accepted beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks.
    // ------------------------------------------------------------------------

    // Sends one tick beat after an optional gap and records its expected result
    // once it is accepted. tvalid is left high so that back-to-back ticks never
    // drop it for a cycle.
    task automatic send_tick(input logic spd, input logic key, input kpd_pkg::t_mode md);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) >= 55) begin
            gap = idle_len();
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, md, key, spd};
        do @(posedge i_clk); while (!s_axis_tready);
        gear_event_q.push_back(advance_tick(spd, key, md));
        ticks_sent++;
    endtask

    // Stops sending and waits until every expected result has come back, then
    // lets the pipeline empty. The block is idle afterwards.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (gear_event_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes one register and tracks it in the predictor. Back-to-back writes
    // keep valid high; the caller lowers it after the last one.
    task automatic cfg_write(input logic [kpd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kpd_pkg::CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            kpd_pkg::CFG_SPEED_WINDOW: win_ticks       = data[kpd_pkg::SPEED_W-1:0];
            kpd_pkg::CFG_MIN_PRESS:    min_press_ticks = data[7:0];
            kpd_pkg::CFG_MIN_RELEASE:  min_rel_ticks   = data[kpd_pkg::RELEASE_W-1:0];
            kpd_pkg::CFG_LONG_PRESS:   long_ticks      = data[kpd_pkg::PRESS_W-1:0];
            kpd_pkg::CFG_HOLD_CAP:     cap_ticks       = data[kpd_pkg::PRESS_W-1:0];
            default: ;
        endcase
    endtask

    // Loads all five timing registers, plus one write to an unused index that
    // the block has to ignore. Only called while the block is idle.
    task automatic set_timing(input int win, input int mp, input int mr, input int lp,
                              input int hc);
        cfg_write(kpd_pkg::CFG_SPEED_WINDOW, cfg_value(win, kpd_pkg::SPEED_W));
        cfg_write(kpd_pkg::CFG_MIN_PRESS,    cfg_value(mp, 8));
        cfg_write(kpd_pkg::CFG_MIN_RELEASE,  cfg_value(mr, kpd_pkg::RELEASE_W));
        cfg_write(kpd_pkg::CFG_LONG_PRESS,   cfg_value(lp, kpd_pkg::PRESS_W));
        cfg_write(kpd_pkg::CFG_HOLD_CAP,     cfg_value(hc, kpd_pkg::PRESS_W));
        cfg_write(kpd_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI)),
                  kpd_pkg::CFG_DAT_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Holds the key at one level for n ticks. With noise on, a tick now and
    // then flips the key (contact bounce) or jumps to another mode.
    task automatic key_ticks(input logic level, input int n, input kpd_pkg::t_mode md,
                             input bit noisy);
        logic           key;
        kpd_pkg::t_mode m;
        for (int i = 0; i < n; i++) begin
            key = level;
            m   = md;
            if (noisy && $urandom_range(0, 49) == 0) begin
                key = ~level;
            end
            if (noisy && $urandom_range(0, 29) == 0) begin
                m = kpd_pkg::t_mode'($urandom_range(MODE_NORMAL, MODE_FAST_DRY));
            end
            send_tick(next_speed(), key, m);
        end
    endtask

    // One press followed by one release, with lengths aimed at the thresholds
    // of the current setting. Some releases are too short, so the next press
    // adds to the pending count; some sequences are release only.
    task automatic press_sequence();
        int             hold;
        int             rel;
        kpd_pkg::t_mode md;
        case ($urandom_range(0, 9))
            0:       hold = $urandom_range(1, kpd_pkg::PRESS_DEBOUNCE);
            1:       hold = min_press_ticks;
            2:       hold = min_press_ticks + 1;
            3:       hold = $urandom_range(1, long_ticks);
            4:       hold = long_ticks - 1;
            5:       hold = long_ticks;
            6:       hold = cap_ticks;
            7:       hold = cap_ticks + $urandom_range(1, 10);
            8:       hold = $urandom_range(1, cap_ticks + 5);
            default: hold = 0;
        endcase
        case ($urandom_range(0, 9))
            7:       rel = $urandom_range(1, min_rel_ticks);
            8:       rel = 0;
            9:       rel = $urandom_range(kpd_pkg::RELEASE_SAT, kpd_pkg::RELEASE_SAT + 5);
            default: rel = min_rel_ticks + $urandom_range(1, 8);
        endcase
        if (hold == 0 && rel == 0) begin
            rel = 1;
        end
        if ($urandom_range(0, 9) < 8) begin
            md = kpd_pkg::t_mode'($urandom_range(MODE_NORMAL, kpd_pkg::MODE_ALTERNATING));
        end else begin
            md = kpd_pkg::t_mode'($urandom_range(MODE_CHILD, MODE_FAST_DRY));
        end
        // Speed edges mostly come inside the window; sometimes the wave is slow
        // enough that the window runs out.
        if ($urandom_range(0, 9) == 0) begin
            spd_half = win_ticks + $urandom_range(0, 20);
        end else begin
            spd_half = $urandom_range(1, win_ticks / 2 + 3);
        end
        key_ticks(KEY_DOWN, hold, md, 1'b1);
        key_ticks(KEY_UP, rel, md, 1'b1);
    endtask

    task automatic run_sequences(input int n);
        int target;
        target = ticks_sent + n;
        while (ticks_sent < target) begin
            press_sequence();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset values: two quick speed edges select the high gear in both speed
    // modes, the forced modes override it, and then a speed pin held high lets
    // the default window run out so the gear falls back to low.
    task automatic test_defaults_and_modes();
        send_tick(1'b0, KEY_UP, MODE_NORMAL);
        send_tick(1'b1, KEY_UP, MODE_NORMAL);
        send_tick(1'b0, KEY_UP, MODE_NORMAL);
        send_tick(1'b1, KEY_UP, kpd_pkg::MODE_ALTERNATING);
        send_tick(1'b1, KEY_DOWN, MODE_CHILD);
        send_tick(1'b0, KEY_DOWN, MODE_FAST_DRY);
        send_tick(1'b1, KEY_UP, MODE_CHILD);
        send_tick(1'b0, KEY_UP, MODE_FAST_DRY);
        for (int i = 0; i < kpd_pkg::RST_SPEED_WINDOW + 1; i++) begin
            send_tick(1'b1, KEY_UP, kpd_pkg::MODE_ALTERNATING);
        end
        settle();
    endtask

    // Small thresholds so that short and long presses both fit in a few
    // dozen ticks. The first stretch runs with no idling on either side.
    task automatic test_short_and_long_presses();
        set_timing(6, 3, 5, 20, 40);
        quiet = 1'b1;
        run_sequences(100);
        quiet = 1'b0;
        run_sequences(300);
        settle();
    endtask

    // Every register at one, its lowest nonzero value.
    task automatic test_low_extremes();
        set_timing(1, 1, 1, 1, 1);
        run_sequences(200);
        settle();
    endtask

    // Several random settings, including a long threshold above the cap and
    // release thresholds up to 99.
    task automatic test_random_settings();
        for (int k = 0; k < 4; k++) begin
            set_timing($urandom_range(1, 24), $urandom_range(1, 20),
                       ($urandom_range(0, 3) == 0) ? 99 : $urandom_range(1, 30),
                       $urandom_range(1, 80), $urandom_range(1, 100));
            run_sequences(130);
            settle();
        end
    endtask

    // A press counted past a cap that is then lowered must not be classified;
    // pressing again clamps it to the new cap, after which it is long.
    task automatic test_cap_lowered_below_count();
        set_timing(4, 5, 6, 30, 50);
        key_ticks(KEY_DOWN, 40, MODE_NORMAL, 1'b0);
        settle();
        set_timing(4, 5, 6, 10, 20);
        key_ticks(KEY_UP, 12, MODE_NORMAL, 1'b0);
        key_ticks(KEY_DOWN, 3, kpd_pkg::MODE_ALTERNATING, 1'b0);
        key_ticks(KEY_UP, 10, kpd_pkg::MODE_ALTERNATING, 1'b1);
        settle();
    endtask

    // Every register at its highest value but the minimum release, which is at 99:
    // a press exactly at the minimum is held, then extended into a short press.
    // Runs without idling to keep it short.
    task automatic test_high_extremes();
        set_timing(255, 255, 99, 16383, 16383);
        quiet    = 1'b1;
        spd_half = 100;
        key_ticks(KEY_DOWN, 255, MODE_NORMAL, 1'b0);
        key_ticks(KEY_UP, 101, MODE_NORMAL, 1'b0);
        spd_half = 200;
        key_ticks(KEY_DOWN, 10, kpd_pkg::MODE_ALTERNATING, 1'b0);
        key_ticks(KEY_UP, 101, kpd_pkg::MODE_ALTERNATING, 1'b0);
        quiet = 1'b0;
        settle();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults_and_modes();
        test_short_and_long_presses();
        test_low_extremes();
        test_random_settings();
        test_cap_lowered_below_count();
        test_high_extremes();

        settle();
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/kpd_pkg.sv
rtl/core/key_press_duration_classifier.sv
sim/tb_key_press_duration_classifier.sv
